// ----- hdl/bic_pkg.sv -----
// Shared constants, types and helpers of the color histogram extractor.
package bic_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int BIN_W          = 6;
    localparam int NUM_BINS       = 64;
    localparam int CNT_W          = 21;
    localparam int VAL_W          = 8;
    localparam int PIX_W          = 24;
    localparam int OUT_W          = 24;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [CFG_W-1:0] CFG_RESET  = 11'd1024;
    localparam logic [0:0]       REG_WIDTH  = 1'b0;
    localparam logic [0:0]       REG_HEIGHT = 1'b1;

    localparam logic [7:0]       LEVEL0_TOP = 8'd64;
    localparam logic [7:0]       LEVEL1_TOP = 8'd128;
    localparam logic [7:0]       LEVEL2_TOP = 8'd192;
    localparam logic [VAL_W-1:0] VAL_MAX    = 8'd255;
    localparam logic [BIN_W-1:0] BIN_LAST   = 6'd63;

    typedef struct packed {
        logic accept;
        logic rd2;
        logic dec;
        logic b1_rd;
        logic b1_wr;
        logic b2_rd;
        logic b2_wr;
        logic advance;
        logic e_rd;
        logic e_ld;
        logic e_div;
        logic e_out;
    } bic_cmd_t;

    typedef struct packed {
        logic need1;
        logic need2;
        logic frame_end;
        logic div_last;
        logic bin_last;
        logic out_free;
    } bic_sts_t;

    function automatic logic [1:0] level_of(input logic [7:0] v);
        logic [1:0] l;
        if (v <= LEVEL0_TOP)
            l = 2'd0;
        else if (v <= LEVEL1_TOP)
            l = 2'd1;
        else if (v <= LEVEL2_TOP)
            l = 2'd2;
        else
            l = 2'd3;
        return l;
    endfunction

endpackage

// ----- hdl/bic_ctrl.sv -----
// Sequencer for pixel classification and the end-of-frame bin emit.
module bic_ctrl
    import bic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bic_sts_t sts,
    output bic_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD2  = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_B1R  = 4'd3;
    localparam logic [3:0] S_B1W  = 4'd4;
    localparam logic [3:0] S_B2R  = 4'd5;
    localparam logic [3:0] S_B2W  = 4'd6;
    localparam logic [3:0] S_ADV  = 4'd7;
    localparam logic [3:0] S_ERD  = 4'd8;
    localparam logic [3:0] S_ELD  = 4'd9;
    localparam logic [3:0] S_EDIV = 4'd10;
    localparam logic [3:0] S_EOUT = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.dec = 1'b1;
                if (sts.need1)
                    state_next = S_B1R;
                else if (sts.need2)
                    state_next = S_B2R;
                else
                    state_next = S_ADV;
            end
            S_B1R:
            begin
                cmd.b1_rd  = 1'b1;
                state_next = S_B1W;
            end
            S_B1W:
            begin
                cmd.b1_wr  = 1'b1;
                state_next = sts.need2 ? S_B2R : S_ADV;
            end
            S_B2R:
            begin
                cmd.b2_rd  = 1'b1;
                state_next = S_B2W;
            end
            S_B2W:
            begin
                cmd.b2_wr  = 1'b1;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = sts.frame_end ? S_ERD : S_IDLE;
            end
            S_ERD:
            begin
                cmd.e_rd   = 1'b1;
                state_next = S_ELD;
            end
            S_ELD:
            begin
                cmd.e_ld   = 1'b1;
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                cmd.e_div = 1'b1;
                if (sts.div_last)
                    state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.e_out  = 1'b1;
                    state_next = sts.bin_last ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/bic_datapath.sv -----
// Line buffers, histogram memories, normalizing divider and output register.
module bic_datapath
    import bic_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bic_cmd_t         cmd,
    output bic_sts_t         sts,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [CFG_W-1:0] cfg_width,
    input  logic [CFG_W-1:0] cfg_height,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [BIN_W-1:0] out_bin,
    output logic [VAL_W-1:0] out_low,
    output logic [VAL_W-1:0] out_high,
    output logic             out_last
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = CW + 1;
    localparam int HW  = RW + 1;
    localparam int AW  = WW + HW;
    localparam int DVW = (AW + VAL_W > CNT_W + VAL_W) ? AW + VAL_W : CNT_W + VAL_W;

    // Clamp geometry
    logic [31:0]   w_full, h_full;
    logic [WW-1:0] w;
    logic [HW-1:0] h;

    always_comb
    begin
        if (cfg_width == '0)
            w_full = 32'd1;
        else if (32'(cfg_width) > 32'(MAX_WIDTH))
            w_full = 32'(MAX_WIDTH);
        else
            w_full = 32'(cfg_width);
        if (cfg_height == '0)
            h_full = 32'd1;
        else if (32'(cfg_height) > 32'(MAX_HEIGHT))
            h_full = 32'(MAX_HEIGHT);
        else
            h_full = 32'(cfg_height);
    end

    assign w = w_full[WW-1:0];
    assign h = h_full[HW-1:0];

    // Position
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    c_now;
    logic [RW-1:0]    r_now;
    logic             outside;
    logic             col_last, row_last, border;
    logic [BIN_W-1:0] bin_reg;
    logic [AW-1:0]    area_reg;

    assign outside  = ({1'b0, col_reg} >= w) || ({1'b0, row_reg} >= h);
    assign c_now    = outside ? '0 : col_reg;
    assign r_now    = outside ? '0 : row_reg;
    assign col_last = ({1'b0, col_reg} == w - WW'(1));
    assign row_last = ({1'b0, row_reg} == h - HW'(1));
    assign border   = (row_reg == RW'(1)) || (col_reg == '0) || col_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            bin_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                col_reg <= c_now;
                row_reg <= r_now;
            end
            else if (cmd.advance)
            begin
                if (col_last && row_last)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    bin_reg <= '0;
                end
                else if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                    col_reg <= col_reg + CW'(1);
            end
            else if (cmd.e_out)
                bin_reg <= bin_reg + BIN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
            area_reg <= AW'(w) * AW'(h);
    end

    // Line buffers
    logic [BIN_W-1:0] row_a_mem [MAX_WIDTH];
    logic [BIN_W-1:0] row_b_mem [MAX_WIDTH];
    logic [CW-1:0]    a_raddr, b_raddr;
    logic [BIN_W-1:0] a_rd, b_rd;
    logic [BIN_W-1:0] code_reg, centre_reg, up_reg;
    logic             sel_high_reg;
    logic             same;

    assign a_raddr = cmd.accept ? c_now : col_reg + CW'(1);
    assign b_raddr = cmd.accept ? c_now : col_reg - CW'(1);
    assign same    = (up_reg == centre_reg) && (code_reg == centre_reg)
                  && (b_rd == centre_reg) && (a_rd == centre_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.rd2)
        begin
            a_rd <= row_a_mem[a_raddr];
            b_rd <= row_b_mem[b_raddr];
        end
        if (cmd.dec)
        begin
            row_a_mem[col_reg] <= code_reg;
            row_b_mem[col_reg] <= centre_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            code_reg <= {level_of(red), level_of(green), level_of(blue)};
        if (cmd.rd2)
        begin
            centre_reg <= a_rd;
            up_reg     <= b_rd;
        end
        if (cmd.dec)
            sel_high_reg <= !border && !same;
    end

    // Histogram memories; an entry with a clear valid bit reads as zero
    logic [CNT_W-1:0]    low_mem  [NUM_BINS];
    logic [CNT_W-1:0]    high_mem [NUM_BINS];
    logic [NUM_BINS-1:0] lo_vld_reg, hi_vld_reg;
    logic [BIN_W-1:0]    cnt_addr, lo_waddr;
    logic [CNT_W-1:0]    lo_rd, hi_rd, lo_cnt, hi_cnt;
    logic                lo_rd_vld_reg, hi_rd_vld_reg;
    logic                lo_we, hi_we;

    always_comb
    begin
        if (cmd.b1_rd)
            cnt_addr = centre_reg;
        else if (cmd.b2_rd)
            cnt_addr = code_reg;
        else
            cnt_addr = bin_reg;
    end

    assign lo_waddr = cmd.b2_wr ? code_reg : centre_reg;
    assign lo_we    = (cmd.b1_wr && !sel_high_reg) || cmd.b2_wr;
    assign hi_we    = cmd.b1_wr && sel_high_reg;
    assign lo_cnt   = lo_rd_vld_reg ? lo_rd : '0;
    assign hi_cnt   = hi_rd_vld_reg ? hi_rd : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.b1_rd || cmd.b2_rd || cmd.e_rd)
        begin
            lo_rd <= low_mem[cnt_addr];
            hi_rd <= high_mem[cnt_addr];
        end
        if (lo_we)
            low_mem[lo_waddr] <= lo_cnt + CNT_W'(1);
        if (hi_we)
            high_mem[centre_reg] <= hi_cnt + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_vld_reg    <= '0;
            hi_vld_reg    <= '0;
            lo_rd_vld_reg <= 1'b0;
            hi_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.b1_rd || cmd.b2_rd || cmd.e_rd)
            begin
                lo_rd_vld_reg <= lo_vld_reg[cnt_addr];
                hi_rd_vld_reg <= hi_vld_reg[cnt_addr];
            end
            if (lo_we)
                lo_vld_reg[lo_waddr] <= 1'b1;
            if (hi_we)
                hi_vld_reg[centre_reg] <= 1'b1;
            // Drop the bin once it has been read for the emit
            if (cmd.e_rd)
            begin
                lo_vld_reg[bin_reg] <= 1'b0;
                hi_vld_reg[bin_reg] <= 1'b0;
            end
        end
    end

    // Restoring divider: count*255 / area, one quotient bit per cycle
    logic [DVW-1:0]   lo_num, hi_num, area8;
    logic [DVW-1:0]   lo_rem_reg, hi_rem_reg, dsr_reg;
    logic [VAL_W-1:0] lo_q_reg, hi_q_reg;
    logic             lo_sat_reg, hi_sat_reg;
    logic [2:0]       div_cnt_reg;

    assign lo_num = (DVW'(lo_cnt) << VAL_W) - DVW'(lo_cnt);
    assign hi_num = (DVW'(hi_cnt) << VAL_W) - DVW'(hi_cnt);
    assign area8  = DVW'(area_reg) << VAL_W;

    always_ff @(posedge clk)
    begin
        if (cmd.e_ld)
        begin
            lo_rem_reg  <= lo_num;
            hi_rem_reg  <= hi_num;
            lo_sat_reg  <= (lo_num >= area8);
            hi_sat_reg  <= (hi_num >= area8);
            dsr_reg     <= DVW'(area_reg) << (VAL_W - 1);
            lo_q_reg    <= '0;
            hi_q_reg    <= '0;
            div_cnt_reg <= 3'd7;
        end
        else if (cmd.e_div)
        begin
            if (lo_rem_reg >= dsr_reg)
            begin
                lo_rem_reg            <= lo_rem_reg - dsr_reg;
                lo_q_reg[div_cnt_reg] <= 1'b1;
            end
            if (hi_rem_reg >= dsr_reg)
            begin
                hi_rem_reg            <= hi_rem_reg - dsr_reg;
                hi_q_reg[div_cnt_reg] <= 1'b1;
            end
            dsr_reg     <= dsr_reg >> 1;
            div_cnt_reg <= div_cnt_reg - 3'd1;
        end
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.e_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.e_out)
        begin
            out_bin  <= bin_reg;
            out_low  <= lo_sat_reg ? VAL_MAX : lo_q_reg;
            out_high <= hi_sat_reg ? VAL_MAX : hi_q_reg;
            out_last <= (bin_reg == BIN_LAST);
        end
    end

    assign out_valid     = out_valid_reg;
    assign sts.need1     = (row_reg != '0);
    assign sts.need2     = row_last;
    assign sts.frame_end = col_last && row_last;
    assign sts.div_last  = (div_cnt_reg == 3'd0);
    assign sts.bin_last  = (bin_reg == BIN_LAST);
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

// ----- hdl/bic_color_histogram_extract.sv -----
// Top level of the border/interior color histogram extractor.
//
//  channel   | dir | beat content
//  s_axis_*  | in  | one RGB pixel in raster order
//  m_axis_*  | out | one normalized bin pair; tlast on bin 63
//  APB       | in  | frame_width at 0x0, frame_height at 0x4
//
// A pixel goes through two line-buffer reads, a decision, then up to two
// read-modify-write updates of the single-port histogram memories.
// After the last pixel of a frame, 64 beats follow, each produced by the
// 8-step restoring divider; no pixel is taken during that emit.
// Reset clears position, histogram valid bits and the output valid flag.
// A stalled output beat holds; the emit waits on the output register.
module bic_color_histogram_extract
    import bic_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,  // bin_index[5:0], low_value[13:6],
                                             // high_value[21:14], zero[23:22]
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Configuration registers; write completes on the access cycle
    logic [CFG_W-1:0] width_reg, height_reg;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[CFG_W-1:0];
            else
                height_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(height_reg) : DATA_W'(width_reg);

    bic_cmd_t         cmd;
    bic_sts_t         sts;
    logic [BIN_W-1:0] out_bin;
    logic [VAL_W-1:0] out_low, out_high;

    bic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bic_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .red        (s_axis_tdata[7:0]),
        .green      (s_axis_tdata[15:8]),
        .blue       (s_axis_tdata[23:16]),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_bin    (out_bin),
        .out_low    (out_low),
        .out_high   (out_high),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_high, out_low, out_bin};

`ifndef SYNTHESIS
    // The frame-closing beat is always the top bin
    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == BIN_LAST))
        else $error("tlast on a bin other than the last");

    // With at least two bins still to come, pixel input stays closed
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast
            && m_axis_tdata[5:0] != 6'd62) |=> !s_axis_tready)
        else $error("pixel input opened during bin emit");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the border/interior color histogram extractor.
module tb;
    import bic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Allow for the slowest legal run: stalled emit beats, pixels with two histogram updates.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles to wait before a register write when no result is pending.
    localparam int QUIET_CYCLES = 40;
    localparam int PHASE_PIXELS = 100;

    typedef enum logic [1:0] {
        OP_WIDTH,   // write frame_width
        OP_HEIGHT,  // write frame_height
        OP_PIXEL,   // send one color a number of times
        OP_FRAME    // send one whole frame of random pixels
    } stim_op_t;

    typedef struct {
        stim_op_t     op;
        logic [23:0]  val;       // register value or pixel {blue, green, red}
        int           reps;
        bit           hand_on;   // frame ends here with one bin at full scale
        logic [5:0]   hand_bin;
    } stim_row_t;

    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic             last;
    } bin_pair_t;

    localparam int NUM_ROWS = 21;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [PIX_W-1:0]  s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // bin_index[5:0], low_value[13:6],
                                            // high_value[21:14], zero[23:22]
    logic              m_axis_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Histogram model state
    logic [BIN_W-1:0] line_up   [MAX_WIDTH_DEF];
    logic [BIN_W-1:0] line_up2  [MAX_WIDTH_DEF];
    logic [CNT_W-1:0] flat_cnt  [NUM_BINS];
    logic [CNT_W-1:0] edge_cnt  [NUM_BINS];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    bin_pair_t bins_due [$];
    stim_row_t steps [NUM_ROWS];
    int        errors = 0;
    int        cycles = 0;
    int        tx_idle = 0;
    int        rx_idle = 0;

    bic_color_histogram_extract i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** bic_color_histogram_extract: FAILED **");
            $finish;
        end
    end

    // Receiver: drop tready at the rate of the current phase.
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Check each output beat against the oldest pending bin.
    always @(posedge clk)
    begin
        bin_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bins_due.size() == 0)
            begin
                $error("unexpected beat: bin_index %0d", m_axis_tdata[5:0]);
                errors++;
            end
            else
            begin
                want = bins_due.pop_front();
                if (m_axis_tdata[5:0] !== want.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", want.bin, m_axis_tdata[5:0]);
                    errors++;
                end
                if (m_axis_tdata[13:6] !== want.lo)
                begin
                    $error("low_value: expected %0d, got %0d", want.lo, m_axis_tdata[13:6]);
                    errors++;
                end
                if (m_axis_tdata[21:14] !== want.hi)
                begin
                    $error("high_value: expected %0d, got %0d", want.hi, m_axis_tdata[21:14]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic logic [1:0] quantize(input logic [7:0] v);
        if (v <= 8'd64)
            return 2'd0;
        if (v <= 8'd128)
            return 2'd1;
        if (v <= 8'd192)
            return 2'd2;
        return 2'd3;
    endfunction

    // Zero acts as one, anything above the maximum as the maximum.
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Classify one accepted pixel; push 64 bin pairs when it closes the frame.
    task automatic histogram_pixel(input logic [23:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        longint unsigned  area;
        longint unsigned  lo;
        longint unsigned  hi;
        logic [BIN_W-1:0] code;
        logic [BIN_W-1:0] mid;
        bit               flat;
        bin_pair_t        p;
        w = eff_dim(width_reg, MAX_WIDTH_DEF);
        h = eff_dim(height_reg, MAX_HEIGHT_DEF);
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        code = {quantize(px[7:0]), quantize(px[15:8]), quantize(px[23:16])};
        // Decide the pixel one row up, same column.
        if (r >= 1)
        begin
            mid = line_up[c];
            if (r == 1 || c == 0 || c == w - 1)
                flat_cnt[mid] = flat_cnt[mid] + 1'b1;
            else
            begin
                flat = line_up2[c] == mid && code == mid
                    && line_up2[c-1] == mid && line_up[c+1] == mid;
                if (flat)
                    flat_cnt[mid] = flat_cnt[mid] + 1'b1;
                else
                    edge_cnt[mid] = edge_cnt[mid] + 1'b1;
            end
        end
        // Bottom row is all border: count it right away.
        if (r == h - 1)
            flat_cnt[code] = flat_cnt[code] + 1'b1;
        line_up2[c] = line_up[c];
        line_up[c] = code;
        if (c + 1 < w)
            col_pos = c + 1;
        else if (r + 1 < h)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            area = longint'(w) * longint'(h);
            for (int b = 0; b < NUM_BINS; b++)
            begin
                lo = (longint'(flat_cnt[b]) * 255) / area;
                hi = (longint'(edge_cnt[b]) * 255) / area;
                p.bin  = BIN_W'(b);
                p.lo   = (lo > 255) ? VAL_MAX : lo[7:0];
                p.hi   = (hi > 255) ? VAL_MAX : hi[7:0];
                p.last = (b == NUM_BINS - 1);
                bins_due.push_back(p);
                flat_cnt[b] = '0;
                edge_cnt[b] = '0;
            end
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // Offer one beat, idling at the phase rate first; tvalid stays high afterwards.
    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        histogram_pixel(px);
    endtask

    // Hold off the stream until all bins are out and the block is quiet.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-CFG_W){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH)
            width_reg = v;
        else
            height_reg = v;
    endtask

    function automatic logic [23:0] rand_pixel;
        return 24'($urandom_range(24'hFFFFFF));
    endfunction

    task automatic send_frame;
        int unsigned n;
        n = eff_dim(width_reg, MAX_WIDTH_DEF) * eff_dim(height_reg, MAX_HEIGHT_DEF);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // Mostly flat patches of one color so that interior pixels occur.
    task automatic send_patchy_frame(output int unsigned n);
        logic [23:0] base;
        logic [23:0] alt;
        bit          noisy;
        n     = eff_dim(width_reg, MAX_WIDTH_DEF) * eff_dim(height_reg, MAX_HEIGHT_DEF);
        base  = rand_pixel();
        alt   = rand_pixel();
        noisy = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (noisy || $urandom_range(99) < 10)
                send_pixel(rand_pixel());
            else if ($urandom_range(99) < 8)
                send_pixel(alt);
            else
                send_pixel(base);
        end
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned n;
        int unsigned w;
        int unsigned h;

        steps = '{
            // zero geometry acts as a single pixel frame
            '{OP_WIDTH,  24'd0,      1, 1'b0, 6'd0},
            '{OP_HEIGHT, 24'd0,      1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'h000000, 1, 1'b1, 6'd0},
            '{OP_PIXEL,  24'hFFFFFF, 1, 1'b1, 6'd63},
            // level edges: 64 -> 0, 65 -> 1, 128 -> 1
            '{OP_PIXEL,  24'h804140, 1, 1'b1, 6'd5},
            // level edges: 129 -> 2, 192 -> 2, 193 -> 3
            '{OP_PIXEL,  24'hC1C081, 1, 1'b1, 6'd43},
            // 3x3 with an odd center pixel: center goes high
            '{OP_WIDTH,  24'd3,      1, 1'b0, 6'd0},
            '{OP_HEIGHT, 24'd3,      1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'hFFFFFF, 4, 1'b0, 6'd0},
            '{OP_PIXEL,  24'h000000, 1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'hFFFFFF, 4, 1'b0, 6'd0},
            // shrink mid-frame: position restarts, counts kept, value saturates
            '{OP_WIDTH,  24'd4,      1, 1'b0, 6'd0},
            '{OP_HEIGHT, 24'd4,      1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'h808080, 6, 1'b0, 6'd0},
            '{OP_WIDTH,  24'd1,      1, 1'b0, 6'd0},
            '{OP_HEIGHT, 24'd1,      1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'h808080, 1, 1'b0, 6'd0},
            // oversize width clamps; the partial row carries its counts over
            '{OP_WIDTH,  24'd2047,   1, 1'b0, 6'd0},
            '{OP_PIXEL,  24'h808080, 8, 1'b0, 6'd0},
            // tall frame, one column wide
            '{OP_WIDTH,  24'd1,      1, 1'b0, 6'd0},
            '{OP_HEIGHT, 24'd24,     1, 1'b0, 6'd0}
        };

        for (int i = 0; i < MAX_WIDTH_DEF; i++)
        begin
            line_up[i]  = '0;
            line_up2[i] = '0;
        end
        for (int b = 0; b < NUM_BINS; b++)
        begin
            flat_cnt[b] = '0;
            edge_cnt[b] = '0;
        end
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = CFG_RESET;
        height_reg = CFG_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, light idling on both sides.
        tx_idle = 31;
        rx_idle = 66;
        foreach (steps[i])
        begin
            case (steps[i].op)
                OP_WIDTH:  write_reg(REG_WIDTH, steps[i].val[CFG_W-1:0]);
                OP_HEIGHT: write_reg(REG_HEIGHT, steps[i].val[CFG_W-1:0]);
                OP_FRAME:  send_frame();
                default:
                begin
                    repeat (steps[i].reps) send_pixel(steps[i].val);
                    // a single pixel frame puts the full scale in its own bin
                    if (steps[i].hand_on)
                    begin
                        for (int k = 0; k < NUM_BINS; k++)
                        begin
                            bins_due[bins_due.size()-NUM_BINS+k].lo =
                                (k == steps[i].hand_bin) ? 8'd255 : 8'd0;
                            bins_due[bins_due.size()-NUM_BINS+k].hi = 8'd0;
                        end
                    end
                end
            endcase
        end
        send_frame();

        // Random frames in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
            rx_idle = (phase == 0) ? 66 : (phase == 1) ? 31 : 0;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                if ($urandom_range(7) == 0)
                begin
                    w = $urandom_range(9, 48);
                    h = $urandom_range(1, 3);
                end
                else
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 6);
                end
                if (w != width_reg)
                    write_reg(REG_WIDTH, CFG_W'(w));
                if (h != height_reg)
                    write_reg(REG_HEIGHT, CFG_W'(h));
                send_patchy_frame(n);
                sent += n;
            end
        end

        drain();
        if (errors == 0)
            $display("** bic_color_histogram_extract: PASSED **");
        else
            $display("** bic_color_histogram_extract: FAILED **");
        $finish;
    end

endmodule
